// ===== rtl/nrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrfc_pkg
// Shared types and constants for the NFC response frame checker.
// ----------------------------------------------------------------------------
package nrfc_pkg;

  localparam logic [7:0] FRAME_MARK   = 8'h00;
  localparam logic [7:0] START_HIGH   = 8'hFF;
  localparam logic [7:0] DIR_TO_HOST  = 8'hD5;
  localparam logic [7:0] HEADER_BYTES = 8'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_EXPECTED_COMMAND = 1'b0;
  localparam logic REG_BUFFER_CAPACITY  = 1'b1;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SC1,
    PH_SC2,
    PH_LEN,
    PH_LCS,
    PH_TFI,
    PH_CODE,
    PH_DATA,
    PH_DCS,
    PH_POST
  } phase_e;

  // One received byte with the compare results worked out by the front end.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       is_mark;
    logic       is_start_high;
    logic       is_dir;
    logic       is_code;
  } nrfc_item_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] capacity;
  } nrfc_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_done;
    logic [1:0] status;
    logic [7:0] data_count;
  } nrfc_result_t;

endpackage

// ===== rtl/nrfc_front.sv =====
// ----------------------------------------------------------------------------
// nrfc_front
// Configuration registers and input classification: each accepted byte is
// compared against the frame constants and the expected response code.
// ----------------------------------------------------------------------------
module nrfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_start_i,
  // toward the queue
  output logic               push_o,
  input  logic               full_i,
  output nrfc_pkg::nrfc_item_t item_o,
  output nrfc_pkg::nrfc_cfg_t  cfg_o
);
  import nrfc_pkg::*;

  logic [7:0] expected_command_q, expected_command_d;
  logic [7:0] buffer_capacity_q, buffer_capacity_d;
  logic [7:0] code;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    expected_command_d = expected_command_q;
    buffer_capacity_d  = buffer_capacity_q;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_EXPECTED_COMMAND: expected_command_d = pwdata[7:0];
        REG_BUFFER_CAPACITY:  buffer_capacity_d  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXPECTED_COMMAND: prdata = {24'd0, expected_command_q};
      REG_BUFFER_CAPACITY:  prdata = {24'd0, buffer_capacity_q};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_command_q <= 8'd0;
      buffer_capacity_q  <= 8'd255;
    end else begin
      expected_command_q <= expected_command_d;
      buffer_capacity_q  <= buffer_capacity_d;
    end
  end

  assign code = expected_command_q + 8'd1;

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  assign item_o.rx_byte       = in_byte_i;
  assign item_o.frame_start   = in_start_i;
  assign item_o.is_mark       = (in_byte_i == FRAME_MARK);
  assign item_o.is_start_high = (in_byte_i == START_HIGH);
  assign item_o.is_dir        = (in_byte_i == DIR_TO_HOST);
  assign item_o.is_code       = (in_byte_i == code);

  assign cfg_o.code     = code;
  assign cfg_o.capacity = buffer_capacity_q;

endmodule

// ===== rtl/nrfc_queue.sv =====
// ----------------------------------------------------------------------------
// nrfc_queue
// Two-entry queue of classified bytes between the front end and the parser.
// ----------------------------------------------------------------------------
module nrfc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nrfc_pkg::nrfc_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output nrfc_pkg::nrfc_item_t item_o
);
  import nrfc_pkg::*;

  nrfc_item_t             entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/nrfc_back.sv =====
// ----------------------------------------------------------------------------
// nrfc_back
// Frame parser: walks the frame one byte per cycle unless stalled, checks
// the length and data checksums, and registers one result per byte.
// ----------------------------------------------------------------------------
module nrfc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  nrfc_pkg::nrfc_item_t  item_i,
  output logic                  pop_o,
  input  nrfc_pkg::nrfc_cfg_t   cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nrfc_pkg::nrfc_result_t result_o
);
  import nrfc_pkg::*;

  phase_e       phase_q, phase_d;
  logic [7:0]   frame_length_q, frame_length_d;
  logic [7:0]   bytes_left_q, bytes_left_d;
  logic [7:0]   running_sum_q, running_sum_d;
  logic         draining_q, draining_d;
  logic         out_valid_q;
  nrfc_result_t result_q, result_d;

  logic [7:0]   payload_len;
  logic [7:0]   lcs_sum;
  logic [7:0]   dcs_sum;
  logic         lcs_ok;
  logic         dcs_ok;

  assign pop_o       = valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign payload_len = frame_length_q - HEADER_BYTES;
  assign lcs_sum     = frame_length_q + item_i.rx_byte;
  assign dcs_sum     = running_sum_q + item_i.rx_byte;
  assign lcs_ok      = (lcs_sum == 8'd0) && (frame_length_q >= HEADER_BYTES);
  assign dcs_ok      = draining_q || (dcs_sum == 8'd0);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (item_i.frame_start) begin
      phase_d = item_i.is_mark ? PH_SC1 : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_SC1:  phase_d = item_i.is_mark ? PH_SC2 : PH_IDLE;
        PH_SC2:  phase_d = item_i.is_start_high ? PH_LEN : PH_IDLE;
        PH_LEN:  phase_d = PH_LCS;
        PH_LCS:  phase_d = lcs_ok ? PH_TFI : PH_IDLE;
        PH_TFI:  phase_d = item_i.is_dir ? PH_CODE : PH_IDLE;
        PH_CODE: begin
          if (!item_i.is_code) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = (payload_len != 8'd0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: phase_d = (bytes_left_q == 8'd1) ? PH_DCS : PH_DATA;
        PH_DCS:  phase_d = dcs_ok ? PH_POST : PH_IDLE;
        PH_POST: phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Result and datapath updates.
  always_comb begin
    frame_length_d = frame_length_q;
    bytes_left_d   = bytes_left_q;
    running_sum_d  = running_sum_q;
    draining_d     = draining_q;
    result_d       = '0;
    if (item_i.frame_start) begin
      draining_d = 1'b0;
      if (!item_i.is_mark) begin
        result_d.frame_done = 1'b1;
        result_d.status     = ST_INVALID;
      end
    end else begin
      unique case (phase_q)
        PH_SC1: begin
          result_d.frame_done = ~item_i.is_mark;
          result_d.status     = item_i.is_mark ? ST_OK : ST_INVALID;
        end
        PH_SC2: begin
          result_d.frame_done = ~item_i.is_start_high;
          result_d.status     = item_i.is_start_high ? ST_OK : ST_INVALID;
        end
        PH_LEN: frame_length_d = item_i.rx_byte;
        PH_LCS: begin
          result_d.frame_done = ~lcs_ok;
          result_d.status     = lcs_ok ? ST_OK : ST_INVALID;
        end
        PH_TFI: begin
          result_d.frame_done = ~item_i.is_dir;
          result_d.status     = item_i.is_dir ? ST_OK : ST_INVALID;
        end
        PH_CODE: begin
          if (!item_i.is_code) begin
            result_d.frame_done = 1'b1;
            result_d.status     = ST_INVALID;
          end else begin
            bytes_left_d  = payload_len;
            draining_d    = (payload_len > cfg_i.capacity);
            running_sum_d = DIR_TO_HOST + cfg_i.code;
          end
        end
        PH_DATA: begin
          if (!draining_q) begin
            result_d.data_byte  = item_i.rx_byte;
            result_d.data_valid = 1'b1;
            running_sum_d       = dcs_sum;
          end
          bytes_left_d = bytes_left_q - 8'd1;
        end
        PH_DCS: begin
          result_d.frame_done = ~dcs_ok;
          result_d.status     = dcs_ok ? ST_OK : ST_INVALID;
        end
        PH_POST: begin
          result_d.frame_done = 1'b1;
          if (draining_q) begin
            draining_d      = 1'b0;
            result_d.status = ST_NOSPACE;
          end else begin
            result_d.status     = ST_OK;
            result_d.data_count = payload_len;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      frame_length_q <= 8'd0;
      bytes_left_q   <= 8'd0;
      running_sum_q  <= 8'd0;
      draining_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q        <= phase_d;
        frame_length_q <= frame_length_d;
        bytes_left_q   <= bytes_left_d;
        running_sum_q  <= running_sum_d;
        draining_q     <= draining_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule

// ===== rtl/nfc_response_frame_checker_core.sv =====
// A byte accepted from the input stream is written into the queue, popped from it by
// the parser into the result register, and offered from there on the result stream.
// Throughput: one byte per cycle while the result stream is not stalled; the parser's
// phase loop in the back end updates once per byte. A two-entry queue absorbs a stall
// on either side.
// Reset: rst_ni (asynchronous, active low) returns the parser to idle, empties the
// queue and output register, and sets expected_command to 0, buffer_capacity to 255.
// ----------------------------------------------------------------------------
// nfc_response_frame_checker_core
// Response frame checker: validates a reader's response frame byte by byte,
// passes payload bytes out and reports ok, invalid frame or no space.
// ----------------------------------------------------------------------------
module nfc_response_frame_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] data_count
  output logic [2:0]  m_axis_tuser,   // [0] data_valid, [2:1] status
  output logic        m_axis_tlast    // frame_done
);
  import nrfc_pkg::*;

  logic         push;
  logic         full;
  logic         pop;
  logic         q_valid;
  nrfc_item_t   front_item;
  nrfc_item_t   q_item;
  nrfc_cfg_t    cfg;
  nrfc_result_t result;

  nrfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item),
    .cfg_o      (cfg)
  );

  nrfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  nrfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .cfg_i       (cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {result.data_count, result.data_byte};
  assign m_axis_tuser = {result.status, result.data_valid};
  assign m_axis_tlast = result.frame_done;

endmodule

// ===== rtl/nrfc_chk.sv =====
// ----------------------------------------------------------------------------
// nrfc_chk
// Port-level checks for the response frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module nrfc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import nrfc_pkg::*;

  // A payload byte never ends a frame.
  a_data_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tlast)
    else $error("payload byte flagged as end of frame");

  // A status other than ok only comes with the end of a frame.
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_OK))
    else $error("status reported outside end of frame");

  // A data count is only reported with a successful end of frame.
  a_count_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[15:8] != 8'd0)) |->
      (m_axis_tlast && (m_axis_tuser[2:1] == ST_OK) && !m_axis_tuser[0]))
    else $error("data count outside a successful end of frame");

  // A stalled result holds its content.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind nfc_response_frame_checker_core nrfc_chk u_nrfc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/nrfc_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfc_scoreboard_pkg
// Expected-result tracking for the response frame checker: a byte-level
// parser model that turns every accepted byte into the result it must cause.
// ----------------------------------------------------------------------------
package nrfc_scoreboard_pkg;

  import nrfc_pkg::*;

  class frame_scoreboard;
    logic [7:0]   command;
    logic [7:0]   capacity;
    phase_e       phase;
    logic [7:0]   frame_len;
    logic [7:0]   bytes_left;
    logic [7:0]   running_sum;
    logic         draining;
    nrfc_result_t outcome;
    nrfc_result_t expected_results[$];
    int unsigned  failures;

    function new();
      command     = 8'h00;
      capacity    = 8'hFF;
      phase       = PH_IDLE;
      frame_len   = 8'h00;
      bytes_left  = 8'h00;
      running_sum = 8'h00;
      draining    = 1'b0;
      failures    = 0;
    endfunction

    function void end_parse(logic [1:0] st, logic [7:0] cnt);
      outcome.frame_done = 1'b1;
      outcome.status     = st;
      outcome.data_count = cnt;
      phase              = PH_IDLE;
    endfunction

    // Advances the parser by one byte and leaves the result in outcome.
    function void parse_byte(logic [7:0] b, logic start);
      logic [7:0] code;
      logic [7:0] sum8;
      code    = command + 8'd1;
      outcome = '0;
      if (start) begin
        draining = 1'b0;
        if (b == FRAME_MARK) phase = PH_SC1;
        else end_parse(ST_INVALID, 8'h00);
        return;
      end
      case (phase)
        PH_SC1: begin
          if (b == FRAME_MARK) phase = PH_SC2;
          else end_parse(ST_INVALID, 8'h00);
        end
        PH_SC2: begin
          if (b == START_HIGH) phase = PH_LEN;
          else end_parse(ST_INVALID, 8'h00);
        end
        PH_LEN: begin
          frame_len = b;
          phase     = PH_LCS;
        end
        PH_LCS: begin
          sum8 = frame_len + b;
          if (sum8 != 8'h00 || frame_len < HEADER_BYTES) end_parse(ST_INVALID, 8'h00);
          else phase = PH_TFI;
        end
        PH_TFI: begin
          if (b == DIR_TO_HOST) phase = PH_CODE;
          else end_parse(ST_INVALID, 8'h00);
        end
        PH_CODE: begin
          if (b != code) begin
            end_parse(ST_INVALID, 8'h00);
          end else begin
            bytes_left  = frame_len - HEADER_BYTES;
            draining    = bytes_left > capacity;
            running_sum = DIR_TO_HOST + code;
            phase       = (bytes_left != 8'h00) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          // Payload is only passed on while the receiver has room for the frame.
          if (!draining) begin
            outcome.data_byte  = b;
            outcome.data_valid = 1'b1;
            running_sum        = running_sum + b;
          end
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) phase = PH_DCS;
        end
        PH_DCS: begin
          sum8 = running_sum + b;
          if (!draining && sum8 != 8'h00) end_parse(ST_INVALID, 8'h00);
          else phase = PH_POST;
        end
        PH_POST: begin
          if (draining) begin
            draining = 1'b0;
            end_parse(ST_NOSPACE, 8'h00);
          end else begin
            end_parse(ST_OK, frame_len - HEADER_BYTES);
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      parse_byte(b, start);
      expected_results.push_back(outcome);
    endfunction

    function void check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
      nrfc_result_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no expected result pending");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (tdata[7:0] != want.data_byte) begin
        $error("data_byte expected %0h actual %0h", want.data_byte, tdata[7:0]);
        failures++;
      end
      if (tuser[0] != want.data_valid) begin
        $error("data_valid expected %0h actual %0h", want.data_valid, tuser[0]);
        failures++;
      end
      if (tlast != want.frame_done) begin
        $error("frame_done expected %0h actual %0h", want.frame_done, tlast);
        failures++;
      end
      if (tuser[2:1] != want.status) begin
        $error("status expected %0h actual %0h", want.status, tuser[2:1]);
        failures++;
      end
      if (tdata[15:8] != want.data_count) begin
        $error("data_count expected %0h actual %0h", want.data_count, tdata[15:8]);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams response frames into the frame checker one byte per transaction:
// a directed opening, then mostly well-formed frames with random payloads
// mixed with corrupted, truncated and short frames and line noise, over
// several register settings and with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

  import nrfc_pkg::*;
  import nrfc_scoreboard_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0; // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] data_byte, [15:8] data_count
  logic [2:0]  m_axis_tuser;        // [0] data_valid, [2:1] status
  logic        m_axis_tlast;        // frame_done

  frame_scoreboard sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_q[$];

  nfc_response_frame_checker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Results are checked before the byte of the same edge is noted; a byte's
  // result never leaves in the cycle it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tuser);
      end
    end
  end

  // Called and returns at a falling edge; valid stays high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_EXPECTED_COMMAND) sb.command = value;
    else sb.capacity = value;
  endtask

  // Builds a well-formed response with random payload and postamble.
  function automatic void build_response(input int unsigned n_data, input logic [7:0] code);
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] d;
    len = 8'(n_data + 2);
    sum = DIR_TO_HOST + code;
    frame_q.delete();
    frame_q.push_back(FRAME_MARK);
    frame_q.push_back(FRAME_MARK);
    frame_q.push_back(START_HIGH);
    frame_q.push_back(len);
    frame_q.push_back(8'h00 - len);
    frame_q.push_back(DIR_TO_HOST);
    frame_q.push_back(code);
    repeat (n_data) begin
      d = 8'($urandom);
      sum = sum + d;
      frame_q.push_back(d);
    end
    frame_q.push_back(8'h00 - sum);
    frame_q.push_back(8'($urandom));
  endfunction

  task automatic send_frame(input int unsigned count);
    for (int i = 0; i < count && i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == 0);
    end
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned n_data;
    int unsigned idx;
    logic [7:0]  code;
    kind   = $urandom_range(99);
    n_data = ($urandom_range(24) == 0) ? $urandom_range(253) : $urandom_range(12);
    code   = sb.command + 8'd1;
    if (kind < 60) begin
      build_response(n_data, code);
      send_frame(frame_q.size());
    end else if (kind < 70) begin
      // One damaged byte anywhere, which also covers bad data checksums.
      build_response(n_data, code);
      idx = $urandom_range(frame_q.size() - 1);
      frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
      send_frame(frame_q.size());
    end else if (kind < 75) begin
      build_response(n_data, code ^ 8'($urandom_range(1, 255)));
      send_frame(frame_q.size());
    end else if (kind < 80) begin
      // Length of zero or one with a matching length checksum.
      build_response(0, code);
      frame_q[3] = 8'($urandom_range(1));
      frame_q[4] = 8'h00 - frame_q[3];
      send_frame(frame_q.size());
    end else if (kind < 90) begin
      // Cut short; the next frame restarts the parser mid-frame.
      build_response(n_data, code);
      send_frame($urandom_range(1, frame_q.size() - 1));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int unsigned phase_end;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening with reset register values.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(FRAME_MARK, 1'b1);
    send_byte(FRAME_MARK, 1'b1);
    send_byte(FRAME_MARK, 1'b0);
    send_byte(START_HIGH, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    build_response(1, sb.command + 8'd1);
    frame_q[8] = frame_q[8] + frame_q[7] - 8'hFF;
    frame_q[7] = 8'hFF;
    send_frame(frame_q.size());
    build_response(0, sb.command + 8'd1);
    frame_q[5] = 8'h00;
    send_frame(6);

    for (int p = 0; p < 8; p++) begin
      s_axis_tvalid <= 1'b0;
      drain_results();
      @(negedge clk_i);
      case (p)
        1: begin
          write_reg(REG_EXPECTED_COMMAND, 8'hFF);
          write_reg(REG_BUFFER_CAPACITY, 8'h00);
        end
        2: begin
          write_reg(REG_EXPECTED_COMMAND, 8'h00);
          write_reg(REG_BUFFER_CAPACITY, 8'hFF);
        end
        3: begin
          write_reg(REG_EXPECTED_COMMAND, 8'($urandom));
          write_reg(REG_BUFFER_CAPACITY, 8'($urandom_range(12)));
        end
        4: begin
          write_reg(REG_EXPECTED_COMMAND, 8'hD4);
          write_reg(REG_BUFFER_CAPACITY, 8'd6);
        end
        5: begin
          write_reg(REG_EXPECTED_COMMAND, 8'($urandom));
          write_reg(REG_BUFFER_CAPACITY, 8'($urandom_range(12)));
        end
        6: begin
          write_reg(REG_EXPECTED_COMMAND, 8'($urandom));
          write_reg(REG_BUFFER_CAPACITY, 8'hFF);
        end
        7: begin
          write_reg(REG_EXPECTED_COMMAND, 8'($urandom));
          write_reg(REG_BUFFER_CAPACITY, 8'($urandom));
        end
        default: ;
      endcase
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      phase_end = bytes_sent + 150;
      if (p == 2) begin
        // Longest possible frame, reported with the largest data count.
        build_response(253, sb.command + 8'd1);
        send_frame(frame_q.size());
      end
      while (bytes_sent < phase_end) begin
        send_random_frame();
        if ($urandom_range(19) == 0) begin
          // The sender goes quiet until every expected result has come.
          s_axis_tvalid <= 1'b0;
          drain_results();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (8) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nrfc_pkg.sv
rtl/nrfc_front.sv
rtl/nrfc_queue.sv
rtl/nrfc_back.sv
rtl/nfc_response_frame_checker_core.sv
rtl/nrfc_chk.sv
verif/nrfc_scoreboard_pkg.sv
verif/tb_top.sv
